[hdl/sih_pkg.sv]
// ============================================================================
// sih_pkg
// Shared types and constants for the string intern hash table.
// ============================================================================
package sih_pkg;

    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
    localparam logic [63:0] HASH_MULT = 64'h00000100000001B3;

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2,
        ST_TOO_LONG = 2'd3
    } t_status;

endpackage

[hdl/string_intern_hash_table_unit.sv]
// ============================================================================
// string_intern_hash_table_unit
// Interns byte strings in a linear-probed FNV-1a hash table held in RAM.
// ============================================================================
// One byte is taken per word. An ordinary byte passes S_IDLE, S_HASH and
// S_HWAIT (hash multiply in two steps plus key buffer write). A last byte
// additionally walks the table: each probe reads the slot header through
// S_PRD, S_PWAIT and S_PCHK, compares the key bytes in S_CMP on a hash and
// length hit, and an insert copies the key byte by byte through S_CPYRD and
// S_CPYWR. After reset, clearing empties the header RAM before the first word.
// ============================================================================
module string_intern_hash_table_unit
    import sih_pkg::*;
#(
    parameter int SLOTS   = 256,
    parameter int MAX_LEN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_key_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_slot,
    output logic [1:0]  o_status,
    output logic [63:0] o_key_hash
);

    localparam int SW = $clog2(SLOTS);
    localparam int KW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int HW = 1 + 64 + LW;
    localparam logic [CW+3:0] LIMIT = (CW+4)'((SLOTS - 1) * 7);

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_HASH   = 12'b000000000100,
        S_HWAIT  = 12'b000000001000,
        S_PRD    = 12'b000000010000,
        S_PWAIT  = 12'b000000100000,
        S_PCHK   = 12'b000001000000,
        S_CMP    = 12'b000010000000,
        S_CPYRD  = 12'b000100000000,
        S_CPYWR  = 12'b001000000000,
        S_DONE   = 12'b010000000000,
        S_OUT    = 12'b100000000000
    } t_state;

    t_state r_st, n_st;

    logic [LW-1:0] r_len;
    logic          r_long;
    logic          r_last;
    logic [7:0]    r_byte;
    logic [SW-1:0] r_idx;
    logic [SW:0]   r_probes;
    logic [LW-1:0] r_pos;
    logic [CW-1:0] r_count;
    logic [SW:0]   r_clr;
    logic [7:0]    r_slot;
    t_status       r_status;
    logic          r_ovalid;
    logic [63:0]   r_ohash;

    logic [63:0]   w_hash;
    logic          w_hclear;

    // Key buffer RAM.
    logic          kb_we;
    logic [KW-1:0] kb_waddr, kb_raddr;
    logic [7:0]    kb_rdata;

    // Slot header RAM: valid, hash, length.
    logic          hd_we;
    logic [SW-1:0] hd_waddr;
    logic [HW-1:0] hd_wdata, hd_rdata;

    // Slot byte RAM.
    logic             by_we;
    logic [SW+KW-1:0] by_waddr, by_raddr;
    logic [7:0]       by_rdata;

    logic w_acc;
    logic w_hit;
    logic w_limit;

    assign w_acc    = i_valid && !o_stall;
    assign o_stall  = (r_st != S_IDLE) || r_ovalid;
    assign w_hclear = (r_st == S_OUT);

    sih_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_acc),
        .i_byte  (i_key_byte),
        .i_clear (w_hclear),
        .o_hash  (w_hash)
    );

    sih_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_kbuf (
        .i_clk(i_clk), .i_we(kb_we), .i_waddr(kb_waddr), .i_wdata(r_byte),
        .i_raddr(kb_raddr), .o_rdata(kb_rdata)
    );

    sih_ram #(.WIDTH(HW), .DEPTH(SLOTS)) u_head (
        .i_clk(i_clk), .i_we(hd_we), .i_waddr(hd_waddr), .i_wdata(hd_wdata),
        .i_raddr(r_idx), .o_rdata(hd_rdata)
    );

    sih_ram #(.WIDTH(8), .DEPTH(SLOTS * MAX_LEN)) u_bytes (
        .i_clk(i_clk), .i_we(by_we), .i_waddr(by_waddr), .i_wdata(kb_rdata),
        .i_raddr(by_raddr), .o_rdata(by_rdata)
    );

    // Key buffer is written while the byte hashes; read during compare/copy.
    assign kb_we    = (r_st == S_HASH) && (r_len < LW'(MAX_LEN));
    assign kb_waddr = r_len[KW-1:0];
    assign kb_raddr = r_pos[KW-1:0];
    assign by_raddr = {r_idx, r_pos[KW-1:0]};
    // The copy writes the byte read in the previous cycle.
    assign by_we    = (r_st == S_CPYWR);
    assign by_waddr = {r_idx, r_pos[KW-1:0]};

    // Header writes: clearing sweep or the insert of a new entry.
    always_comb begin
        hd_we    = 1'b0;
        hd_waddr = r_idx;
        hd_wdata = {1'b1, w_hash, r_len};
        if (r_st == S_CLEAR) begin
            hd_we    = 1'b1;
            hd_waddr = r_clr[SW-1:0];
            hd_wdata = '0;
        end else if (r_st == S_DONE && r_status == ST_INSERTED) begin
            hd_we = 1'b1;
        end
    end

    assign w_hit   = (hd_rdata[HW-2:LW] == w_hash) && (hd_rdata[LW-1:0] == r_len);
    assign w_limit = (((CW+4)'(r_count) + (CW+4)'(1)) << 3) >= LIMIT;

    // Sequencer.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_CLEAR: if (r_clr == (SW+1)'(SLOTS - 1)) n_st = S_IDLE;
            S_IDLE:  if (w_acc) n_st = S_HASH;
            S_HASH:  n_st = S_HWAIT;
            S_HWAIT: begin
                if (!r_last)     n_st = S_IDLE;
                else if (r_long) n_st = S_DONE;
                else             n_st = S_PRD;
            end
            S_PRD:   n_st = S_PWAIT;
            S_PWAIT: n_st = S_PCHK;
            S_PCHK: begin
                if (!hd_rdata[HW-1])            n_st = w_limit ? S_DONE : S_CPYRD;
                else if (w_hit)                 n_st = S_CMP;
                else if (r_probes == (SW+1)'(SLOTS - 1)) n_st = S_DONE;
                else                            n_st = S_PRD;
            end
            S_CMP: begin
                if (r_pos != '0 && kb_rdata != by_rdata) begin
                    n_st = (r_probes == (SW+1)'(SLOTS - 1)) ? S_DONE : S_PRD;
                end else if (r_pos == r_len) begin
                    n_st = S_DONE;
                end
            end
            S_CPYRD: n_st = (r_pos == r_len) ? S_DONE : S_CPYWR;
            S_CPYWR: n_st = S_CPYRD;
            S_DONE:  n_st = S_OUT;
            S_OUT:   n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // Compare reads key and slot byte at r_pos-1; both reads are issued at
    // r_pos and land next cycle, so compare uses r_pos as a one-ahead index.
    logic [LW-1:0] w_cmp_pos;
    assign w_cmp_pos = r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_CLEAR;
            r_clr    <= '0;
            r_len    <= '0;
            r_long   <= 1'b0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_st) inside
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: begin
                    r_byte <= i_key_byte;
                    r_last <= i_last_byte;
                end
                S_HASH: begin
                    if (r_len < LW'(MAX_LEN)) r_len <= r_len + 1'b1;
                    else                      r_long <= 1'b1;
                end
                S_HWAIT: begin
                    r_idx    <= w_hash[SW-1:0];
                    r_probes <= '0;
                    r_slot   <= 8'd0;
                    r_status <= r_long ? ST_TOO_LONG : ST_FULL;
                end
                S_PRD, S_PWAIT: ;
                S_PCHK: begin
                    r_pos <= '0;
                    if (!hd_rdata[HW-1]) begin
                        if (!w_limit) begin
                            r_status <= ST_INSERTED;
                            r_slot   <= 8'(r_idx);
                        end
                    end else if (!w_hit) begin
                        r_idx    <= r_idx + 1'b1;
                        r_probes <= r_probes + 1'b1;
                    end
                end
                S_CMP: begin
                    // A byte mismatch is checked before the end of the key.
                    if (w_cmp_pos != '0 && kb_rdata != by_rdata) begin
                        r_idx    <= r_idx + 1'b1;
                        r_probes <= r_probes + 1'b1;
                    end else if (r_pos == r_len) begin
                        r_status <= ST_FOUND;
                        r_slot   <= 8'(r_idx);
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_CPYRD: ;
                S_CPYWR: r_pos <= r_pos + 1'b1;
                S_DONE: begin
                    if (r_status == ST_INSERTED) r_count <= r_count + 1'b1;
                end
                S_OUT: begin
                    r_ovalid   <= 1'b1;
                    o_slot     <= r_slot;
                    o_status   <= r_status;
                    o_key_hash <= w_hash;
                    r_len      <= '0;
                    r_long     <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_ovalid;

endmodule

[hdl/sih_ram.sv]
// ============================================================================
// sih_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module sih_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[hdl/sih_hash.sv]
// ============================================================================
// sih_hash
// FNV-1a 64-bit running hash; each byte is folded into the finished hash of the
// byte before. The multiplier is 2^40 + 0x1B3, so the product is a sum of
// shifted copies: stage one forms two partial sums and stage two adds them.
// ============================================================================
module sih_hash
    import sih_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [7:0]  i_byte,
    input  logic        i_clear,
    output logic [63:0] o_hash
);

    logic [63:0] r_hash;
    logic [63:0] r_pl;
    logic [63:0] r_ph;
    logic        r_busy;
    logic [63:0] w_x;

    assign w_x = r_hash ^ {56'd0, i_byte};

    // Stage one forms two partial sums of the shifted terms.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_pl <= (w_x << 40) + (w_x << 8) + (w_x << 7) + w_x;
            r_ph <= (w_x << 5) + (w_x << 4) + (w_x << 1);
        end
    end

    // Stage two sums them into the running hash.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= FNV_BASIS;
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_start;
            if (i_clear) begin
                r_hash <= FNV_BASIS;
            end else if (r_busy) begin
                r_hash <= r_pl + r_ph;
            end
        end
    end

    assign o_hash = r_hash;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking testbench for the string intern hash table. Strings are sent
// as byte words with a last flag, an in-bench model of the FNV-1a table
// predicts every result word, and a checker compares them field by field.
// ============================================================================
module tb;
    import sih_pkg::*;

    localparam int SLOTS     = 256;
    localparam int MAX_LEN   = 64;
    localparam int POOL      = 48;
    localparam int POOL_W    = 80;
    localparam int IDLE_MAX  = 100000;
    localparam int RAND_WORDS = 800;

    typedef struct packed {
        logic [7:0]  slot;
        t_status     status;
        logic [63:0] hash;
    } t_intern_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_key_byte;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_slot;
    logic [1:0]  o_status;
    logic [63:0] o_key_hash;

    string_intern_hash_table_unit #(.SLOTS(SLOTS), .MAX_LEN(MAX_LEN)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_key_byte  (i_key_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_slot      (o_slot),
        .o_status    (o_status),
        .o_key_hash  (o_key_hash)
    );

    // Table model state.
    logic [63:0] cur_hash;
    logic [7:0]  cur_key [MAX_LEN];
    int          cur_len;
    bit          cur_too_long;
    bit          tbl_valid [SLOTS];
    logic [63:0] tbl_hash [SLOTS];
    int          tbl_len [SLOTS];
    logic [7:0]  tbl_bytes [SLOTS][MAX_LEN];
    int          tbl_count;

    t_intern_result pending_results[$];

    // Bookkeeping.
    int mismatches;
    int results_seen;
    int status_seen [4];
    int words_sent;
    int idle_cycles;
    int burst_left;

    // Strings kept for reuse so that lookups hit stored entries.
    logic [7:0] pool_bytes [POOL][POOL_W];
    int         pool_len [POOL];
    int         pool_fill;
    logic [7:0] str_buf [POOL_W];

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Fold one byte into the model; on the last byte, search the table.
    task automatic intern_model(input logic [7:0] b, input logic last);
        t_intern_result r;
        int start;
        int s;
        bit hit;
        bit empty_seen;
        int empty_slot;
        begin
            cur_hash = (cur_hash ^ {56'd0, b}) * HASH_MULT;
            if (cur_len < MAX_LEN) begin
                cur_key[cur_len] = b;
                cur_len++;
            end else begin
                cur_too_long = 1'b1;
            end
            if (last) begin
                r.slot   = 8'd0;
                r.hash   = cur_hash;
                hit      = 1'b0;
                empty_seen = 1'b0;
                empty_slot = 0;
                if (cur_too_long) begin
                    r.status = ST_TOO_LONG;
                end else begin
                    start = int'(cur_hash % SLOTS);
                    for (int i = 0; i < SLOTS; i++) begin
                        s = (start + i) % SLOTS;
                        if (!tbl_valid[s]) begin
                            empty_seen = 1'b1;
                            empty_slot = s;
                            break;
                        end
                        if (tbl_hash[s] == cur_hash && tbl_len[s] == cur_len) begin
                            hit = 1'b1;
                            for (int k = 0; k < cur_len; k++)
                                if (tbl_bytes[s][k] != cur_key[k]) hit = 1'b0;
                            if (hit) begin
                                r.slot = s[7:0];
                                break;
                            end
                        end
                    end
                    if (hit) begin
                        r.status = ST_FOUND;
                    end else if (!empty_seen || (tbl_count + 1) * 8 >= (SLOTS - 1) * 7) begin
                        r.status = ST_FULL;
                    end else begin
                        tbl_valid[empty_slot] = 1'b1;
                        tbl_hash[empty_slot]  = cur_hash;
                        tbl_len[empty_slot]   = cur_len;
                        for (int k = 0; k < cur_len; k++)
                            tbl_bytes[empty_slot][k] = cur_key[k];
                        tbl_count++;
                        r.slot   = empty_slot[7:0];
                        r.status = ST_INSERTED;
                    end
                end
                pending_results.push_back(r);
                cur_hash     = FNV_BASIS;
                cur_len      = 0;
                cur_too_long = 1'b0;
            end
        end
    endtask

    // Send one byte word, with random gaps between bursts.
    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        begin
            @(negedge i_clk);
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    i_valid = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            burst_left--;
            i_valid     = 1'b1;
            i_key_byte  = b;
            i_last_byte = last;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            intern_model(b, last);
            words_sent++;
        end
    endtask

    // Send the first n bytes of str_buf as one string.
    task automatic send_string(input int n);
        begin
            for (int k = 0; k < n; k++)
                send_word(str_buf[k], k == n - 1);
        end
    endtask

    task automatic drop_valid();
        begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
    endtask

    task automatic wait_drained();
        begin
            while (pending_results.size() != 0) @(posedge i_clk);
        end
    endtask

    // Directed: byte extremes, a repeat lookup, exact and over-long lengths.
    task automatic test_directed();
        begin
            str_buf[0] = 8'h00;
            send_string(1);
            str_buf[0] = 8'hFF;
            send_string(1);
            str_buf[0] = 8'h00;
            send_string(1);
            for (int k = 0; k < MAX_LEN; k++) str_buf[k] = 8'(k * 37 + 1);
            send_string(MAX_LEN);
            send_string(MAX_LEN);
            for (int k = 0; k < MAX_LEN + 1; k++) str_buf[k] = 8'(k ^ 8'hA5);
            send_string(MAX_LEN + 1);
            str_buf[0] = 8'h55;
            str_buf[1] = 8'hAA;
            send_string(2);
            send_string(2);
        end
    endtask

    // Random strings, about half of them reused from a pool.
    task automatic test_random();
        int n;
        int p;
        int start_words;
        bit paused;
        begin
            start_words = words_sent;
            paused = 1'b0;
            while (words_sent - start_words < RAND_WORDS) begin
                if (pool_fill > 0 && $urandom_range(0, 1) == 0) begin
                    p = $urandom_range(0, pool_fill - 1);
                    n = pool_len[p];
                    for (int k = 0; k < n; k++) str_buf[k] = pool_bytes[p][k];
                end else begin
                    case ($urandom_range(0, 9))
                        0:       n = $urandom_range(MAX_LEN - 2, POOL_W);
                        1, 2:    n = $urandom_range(13, MAX_LEN);
                        default: n = $urandom_range(1, 12);
                    endcase
                    for (int k = 0; k < n; k++) str_buf[k] = 8'($urandom);
                    if (pool_fill < POOL) begin
                        p = pool_fill;
                        pool_fill = pool_fill + 1;
                    end else begin
                        p = $urandom_range(0, POOL - 1);
                    end
                    pool_len[p] = n;
                    for (int k = 0; k < n; k++) pool_bytes[p][k] = str_buf[k];
                end
                send_string(n);
                // Hold off once until the table has answered everything.
                if (!paused && words_sent - start_words > RAND_WORDS / 2) begin
                    paused = 1'b1;
                    drop_valid();
                    wait_drained();
                end
            end
        end
    endtask

    // Fill the table past its load limit, then look up a stored string.
    task automatic test_fill();
        begin
            for (int i = 0; i < 240; i++) begin
                str_buf[0] = 8'hC3;
                str_buf[1] = 8'(i);
                str_buf[2] = 8'(i >> 8) ^ 8'h3C;
                send_string(3);
            end
            str_buf[0] = 8'hC3;
            str_buf[1] = 8'd5;
            str_buf[2] = 8'h3C;
            send_string(3);
            str_buf[0] = 8'h00;
            send_string(1);
        end
    endtask

    // Receiver stall pattern: modes of none, light and heavy stalling.
    initial begin
        int mode;
        int run;
        i_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            run  = $urandom_range(30, 300);
            repeat (run) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_stall = 1'b0;
                    1:       i_stall = ($urandom_range(0, 3) == 0);
                    default: i_stall = ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_intern_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            status_seen[o_status]++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: slot=%0d status=%0d hash=%h",
                             o_slot, o_status, o_key_hash);
            end else begin
                e = pending_results.pop_front();
                if (o_slot !== e.slot || o_status !== e.status || o_key_hash !== e.hash) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected slot=%0d status=%0d hash=%h, got slot=%0d status=%0d hash=%h",
                                 results_seen, e.slot, e.status, e.hash,
                                 o_slot, o_status, o_key_hash);
                end
            end
        end
    end

    // Watchdog on cycles with no word moving on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_MAX) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_key_byte   = 8'd0;
        i_last_byte  = 1'b0;
        cur_hash     = FNV_BASIS;
        cur_len      = 0;
        cur_too_long = 1'b0;
        tbl_count    = 0;
        for (int s = 0; s < SLOTS; s++) tbl_valid[s] = 1'b0;
        mismatches   = 0;
        results_seen = 0;
        for (int k = 0; k < 4; k++) status_seen[k] = 0;
        words_sent   = 0;
        idle_cycles  = 0;
        burst_left   = 0;
        pool_fill    = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random();
        test_fill();
        drop_valid();
        wait_drained();
        repeat (2000) @(negedge i_clk);

        $display("Sent %0d byte words; checked %0d results (found %0d, inserted %0d,",
                 words_sent, results_seen, status_seen[0], status_seen[1]);
        $display("refused %0d, too long %0d); %0d entries stored.",
                 status_seen[2], status_seen[3], tbl_count);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
